[rtl/rsc_pkg.sv]
// Shared types, constants and helpers of the ray/sphere closest-hit block.
`timescale 1ns / 1ps
package rsc_pkg;
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 32;
   localparam int LEN_W      = 31;
   localparam int CNT_W      = 5;
   localparam int ACC_W      = 64;
   localparam int SQRT_STEPS = 32;
   localparam int Q_W        = COORD_W + 3;
   localparam int DIVN_W     = Q_W + FRAC_BITS;
   localparam int DIVD_W     = Q_W;

   localparam logic [LEN_W-1:0]        LEN_ONES = '1;
   localparam logic signed [ACC_W-1:0] S32_HI   = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] S32_LO   = -64'sh0000_0000_8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_DIFF, ST_MUL, ST_CHECK, ST_SQRT,
      ST_QUOT, ST_DIV, ST_DECIDE, ST_ADVANCE, ST_RESP
   } state_type;

   // Steps of the shared multiplier for one sphere test.
   typedef enum logic [3:0] {
      MS_AXX, MS_AYY, MS_AZZ, MS_HX, MS_HY, MS_HZ, MS_CX, MS_CY, MS_CZ,
      MS_RR, MS_GAP, MS_SAT, MS_HH, MS_AC, MS_DISC
   } mstep_type;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_TRACE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic              valid;
      logic [ACC_W-1:0]  rem;
      logic [ACC_W-1:0]  root;
   } sqrt_beat_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > S32_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < S32_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction
endpackage

[rtl/ray_sphere_closest_hit_top.sv]
// Top level of the ray/sphere closest-hit block: sphere table, sequencer and datapath.
// Usage: a beat on the request side is taken when start is high and busy is low.
// req_type selects a load (writes req_slot of the sphere table with center
// req_pos_* and radius req_length) or a trace (ray origin req_pos_*, direction
// req_dir_*, limit req_length, all ones meaning no limit).
// A load gives no result; busy stays low. A trace tests the entries from 0 up to
// min(sphere_count, MAX_SPHERES)-1 in order and gives one result beat:
// rsp_valid is high for one cycle with rsp_hit, rsp_hit_index and rsp_hit_dist.
// Per sphere the sequencer runs fetch and offset, the multiplier sequence, check,
// the 32-cell square root chain, divider start, the two parallel 50-step dividers,
// decide and advance; a sphere whose discriminant is negative or whose squared
// direction length a is zero goes from check straight to advance. The result beat
// is registered from the response state that follows the last sphere.
// One trace is in work at a time; busy is high from the accepting edge until the
// result beat is shown, and the next beat can be taken at the edge that ends it.
// The result cannot be held off: it is shown for exactly one cycle.
// The user must write sphere_count through csr_we/csr_wdata while the block is idle; it is not enforced.
// Synchronous reset clears the sequencer and sphere_count; the table keeps its
// contents and must be loaded before it is traced.
`timescale 1ns / 1ps
module ray_sphere_closest_hit_top
   import rsc_pkg::*;
#(
   parameter int MAX_SPHERES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_type,
   input  logic [3:0]                req_slot,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic signed [COORD_W-1:0] req_dir_x,
   input  logic signed [COORD_W-1:0] req_dir_y,
   input  logic signed [COORD_W-1:0] req_dir_z,
   input  logic [LEN_W-1:0]          req_length,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic [3:0]                rsp_hit_index,
   output logic [LEN_W-1:0]          rsp_hit_dist,
   input  logic                      csr_we,
   input  logic [CNT_W-1:0]          csr_wdata
);
   localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam logic [8:0] MAX_N = 9'(MAX_SPHERES);
   localparam logic signed [DIVN_W-1:0] DIST_MAX = DIVN_W'(LEN_ONES);

   // Sphere table.
   logic signed [COORD_W-1:0] tbl_cx [MAX_SPHERES];
   logic signed [COORD_W-1:0] tbl_cy [MAX_SPHERES];
   logic signed [COORD_W-1:0] tbl_cz [MAX_SPHERES];
   logic [LEN_W-1:0]          tbl_rad [MAX_SPHERES];

   state_type state_ff, state_in;
   mstep_type mstep_ff, mstep_in;
   logic [CNT_W-1:0] csr_count_ff, k_ff, k_in, n_eff;
   logic [CNT_W:0]   k_next;

   logic accept, trace_go, load_go, slot_ok;
   logic sqrt_go, div_go, issue, early_miss;

   logic signed [COORD_W-1:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, cz_ff, lx_ff, ly_ff, lz_ff;
   logic [LEN_W-1:0]          rad_ff, len_ff;
   logic signed [COORD_W-1:0] a_ff, h_ff, c_ff, mul_a, mul_b;
   logic signed [ACC_W-1:0]   prod_ff, acc_a_ff, acc_h_ff, acc_c_ff, hh_ff, disc_ff;
   logic                      iss_ff;
   mstep_type                 tag_ff;
   logic signed [Q_W-1:0]     q_ff, h_ext, s_ext;

   sqrt_beat_type sq_chain [SQRT_STEPS+1];

   logic signed [DIVN_W-1:0] num0, num1, t0, t1, tlo, thi, tsel;
   logic signed [DIVD_W-1:0] den0;
   logic                     d0_done, d1_done, t_ok, better;

   logic signed [DIVN_W-1:0] best_ff;
   logic                     inf_ff, hit_ff;
   logic [CNT_W-1:0]         idx_ff;

   logic                     rsp_valid_ff, rsp_hit_ff;
   logic [3:0]               rsp_index_ff;
   logic [LEN_W-1:0]         rsp_dist_ff;

   assign accept   = start && !busy;
   assign trace_go = accept && (req_type == REQ_TRACE);
   assign load_go  = accept && (req_type == REQ_LOAD);
   assign slot_ok  = {5'b0, req_slot} < MAX_N;
   assign n_eff    = ({4'b0, csr_count_ff} > MAX_N) ? MAX_N[CNT_W-1:0] : csr_count_ff;
   assign k_next   = {1'b0, k_ff} + 6'd1;
   assign early_miss = (a_ff == '0) || disc_ff[ACC_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= '0;
      end else if (csr_we) begin
         csr_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (load_go && slot_ok) begin
         tbl_cx[IDX_W'(req_slot)]  <= req_pos_x;
         tbl_cy[IDX_W'(req_slot)]  <= req_pos_y;
         tbl_cz[IDX_W'(req_slot)]  <= req_pos_z;
         tbl_rad[IDX_W'(req_slot)] <= req_length;
      end
      if (state_ff == ST_FETCH) begin
         cx_ff  <= tbl_cx[IDX_W'(k_ff)];
         cy_ff  <= tbl_cy[IDX_W'(k_ff)];
         cz_ff  <= tbl_cz[IDX_W'(k_ff)];
         rad_ff <= tbl_rad[IDX_W'(k_ff)];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (trace_go) begin
               state_in = (n_eff == '0) ? ST_RESP : ST_FETCH;
            end
         end
         ST_FETCH:   state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_MUL;
         ST_MUL: begin
            if (mstep_ff == MS_DISC) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:   state_in = early_miss ? ST_ADVANCE : ST_SQRT;
         ST_SQRT: begin
            if (sq_chain[SQRT_STEPS].valid) begin
               state_in = ST_QUOT;
            end
         end
         ST_QUOT:    state_in = ST_DIV;
         ST_DIV: begin
            if (d0_done && d1_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE:  state_in = ST_ADVANCE;
         ST_ADVANCE: state_in = (k_next < {1'b0, n_eff}) ? ST_FETCH : ST_RESP;
         ST_RESP:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy    = state_ff != ST_IDLE;
      sqrt_go = (state_ff == ST_CHECK) && !early_miss;
      div_go  = state_ff == ST_QUOT;
      issue   = (state_ff == ST_MUL) &&
                ((mstep_ff <= MS_RR) || (mstep_ff == MS_HH) || (mstep_ff == MS_AC));
      mstep_in = mstep_ff;
      k_in     = k_ff;
      if (state_ff == ST_DIFF) begin
         mstep_in = MS_AXX;
      end else if ((state_ff == ST_MUL) && (mstep_ff != MS_DISC)) begin
         mstep_in = mstep_type'(4'(mstep_ff + 4'd1));
      end
      if (trace_go) begin
         k_in = '0;
      end else if (state_ff == ST_ADVANCE) begin
         k_in = k_next[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mstep_ff <= MS_AXX;
         k_ff     <= '0;
         iss_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         mstep_ff <= mstep_in;
         k_ff     <= k_in;
         iss_ff   <= issue;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (mstep_ff)
         MS_AXX: begin mul_a = dx_ff; mul_b = dx_ff; end
         MS_AYY: begin mul_a = dy_ff; mul_b = dy_ff; end
         MS_AZZ: begin mul_a = dz_ff; mul_b = dz_ff; end
         MS_HX:  begin mul_a = dx_ff; mul_b = lx_ff; end
         MS_HY:  begin mul_a = dy_ff; mul_b = ly_ff; end
         MS_HZ:  begin mul_a = dz_ff; mul_b = lz_ff; end
         MS_CX:  begin mul_a = lx_ff; mul_b = lx_ff; end
         MS_CY:  begin mul_a = ly_ff; mul_b = ly_ff; end
         MS_CZ:  begin mul_a = lz_ff; mul_b = lz_ff; end
         MS_RR: begin
            mul_a = $signed({1'b0, rad_ff});
            mul_b = $signed({1'b0, rad_ff});
         end
         MS_HH:  begin mul_a = h_ff; mul_b = h_ff; end
         MS_AC:  begin mul_a = a_ff; mul_b = c_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (trace_go) begin
         ox_ff   <= req_pos_x;
         oy_ff   <= req_pos_y;
         oz_ff   <= req_pos_z;
         dx_ff   <= req_dir_x;
         dy_ff   <= req_dir_y;
         dz_ff   <= req_dir_z;
         len_ff  <= req_length;
      end
      if (state_ff == ST_DIFF) begin
         lx_ff    <= sat32(ACC_W'(ox_ff) - ACC_W'(cx_ff));
         ly_ff    <= sat32(ACC_W'(oy_ff) - ACC_W'(cy_ff));
         lz_ff    <= sat32(ACC_W'(oz_ff) - ACC_W'(cz_ff));
         acc_a_ff <= '0;
         acc_h_ff <= '0;
         acc_c_ff <= '0;
      end
      if (issue) begin
         prod_ff <= ACC_W'(mul_a) * ACC_W'(mul_b);
         tag_ff  <= mstep_ff;
      end
      // Each product that goes into a, h or c is floored to the fraction width first.
      if (iss_ff) begin
         unique case (tag_ff)
            MS_AXX, MS_AYY, MS_AZZ: acc_a_ff <= acc_a_ff + (prod_ff >>> FRAC_BITS);
            MS_HX, MS_HY, MS_HZ:    acc_h_ff <= acc_h_ff + (prod_ff >>> FRAC_BITS);
            MS_CX, MS_CY, MS_CZ:    acc_c_ff <= acc_c_ff + (prod_ff >>> FRAC_BITS);
            MS_RR:                  acc_c_ff <= acc_c_ff - (prod_ff >>> FRAC_BITS);
            MS_HH:                  hh_ff    <= prod_ff;
            MS_AC:                  disc_ff  <= hh_ff - prod_ff;
            default: ;
         endcase
      end
      if ((state_ff == ST_MUL) && (mstep_ff == MS_SAT)) begin
         a_ff <= sat32(acc_a_ff);
         h_ff <= sat32(acc_h_ff);
         c_ff <= sat32(acc_c_ff);
      end
      if ((state_ff == ST_SQRT) && sq_chain[SQRT_STEPS].valid) begin
         q_ff <= (h_ff > 0) ? -(h_ext + s_ext) : (s_ext - h_ext);
      end
   end

   assign sq_chain[0] = '{valid: sqrt_go, rem: disc_ff, root: '0};

   for (genvar gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
      rsc_sqrt_cell #(.STEP(gi)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (sq_chain[gi]),
         .beat_out (sq_chain[gi+1])
      );
   end

   assign h_ext = Q_W'(h_ff);
   assign s_ext = $signed({3'b000, sq_chain[SQRT_STEPS].root[COORD_W-1:0]});

   assign num0 = DIVN_W'(q_ff) <<< FRAC_BITS;
   assign den0 = DIVD_W'(a_ff);
   assign num1 = DIVN_W'(c_ff) <<< FRAC_BITS;

   rsc_div u_div_a (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (num0),
      .den   (den0),
      .done  (d0_done),
      .quo   (t0)
   );

   rsc_div u_div_c (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (num1),
      .den   (q_ff),
      .done  (d1_done),
      .quo   (t1)
   );

   // A zero discriminant has a double root; the second quotient is then unused.
   always_comb begin
      logic signed [DIVN_W-1:0] tb;
      tb   = (disc_ff == '0) ? t0 : t1;
      tlo  = (t0 > tb) ? tb : t0;
      thi  = (t0 > tb) ? t0 : tb;
      tsel = tlo[DIVN_W-1] ? thi : tlo;
      t_ok = !thi[DIVN_W-1];
      better = t_ok && (inf_ff || (tsel < best_ff));
   end

   always_ff @(posedge clock) begin
      if (trace_go) begin
         best_ff <= DIVN_W'(req_length);
         inf_ff  <= req_length == LEN_ONES;
         hit_ff  <= 1'b0;
         idx_ff  <= '0;
      end else if ((state_ff == ST_DECIDE) && better) begin
         best_ff <= tsel;
         inf_ff  <= 1'b0;
         hit_ff  <= 1'b1;
         idx_ff  <= k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= state_ff == ST_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RESP) begin
         rsp_hit_ff   <= hit_ff;
         rsp_index_ff <= hit_ff ? idx_ff[3:0] : 4'd0;
         if (!hit_ff) begin
            rsp_dist_ff <= len_ff;
         end else if (best_ff > DIST_MAX) begin
            rsp_dist_ff <= LEN_ONES;
         end else begin
            rsp_dist_ff <= best_ff[LEN_W-1:0];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_index = rsp_index_ff;
   assign rsp_hit_dist  = rsp_dist_ff;
endmodule

[rtl/rsc_sqrt_cell.sv]
// One cell of the square root chain: a single bit-pair step, registered.
`timescale 1ns / 1ps
module rsc_sqrt_cell
   import rsc_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  sqrt_beat_type beat_in,
   output sqrt_beat_type beat_out
);
   localparam logic [ACC_W-1:0] BIT = ACC_W'(64'd1) << (62 - 2 * STEP);

   logic             valid_ff;
   logic [ACC_W-1:0] rem_ff, root_ff;
   logic [ACC_W-1:0] trial, rem_in, root_in;

   always_comb begin
      trial = beat_in.root + BIT;
      if (beat_in.rem >= trial) begin
         rem_in  = beat_in.rem - trial;
         root_in = (beat_in.root >> 1) + BIT;
      end else begin
         rem_in  = beat_in.rem;
         root_in = beat_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign beat_out = '{valid: valid_ff, rem: rem_ff, root: root_ff};
endmodule

[rtl/rsc_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module rsc_div
   import rsc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic signed [DIVN_W-1:0] num,
   input  logic signed [DIVD_W-1:0] den,
   output logic                     done,
   output logic signed [DIVN_W-1:0] quo
);
   localparam int NM_W  = DIVN_W - 1;
   localparam int DM_W  = DIVD_W - 1;
   localparam int CW    = $clog2(NM_W);

   logic                 busy_ff, done_ff, neg_ff;
   logic [CW-1:0]        cnt_ff;
   logic [NM_W-1:0]      nq_ff;
   logic [DM_W-1:0]      rem_ff, dmag_ff;
   logic signed [DIVN_W-1:0] num_abs;
   logic signed [DIVD_W-1:0] den_abs;
   logic [DM_W:0]        trial;
   logic                 take;

   assign num_abs = num[DIVN_W-1] ? -num : num;
   assign den_abs = den[DIVD_W-1] ? -den : den;
   assign trial   = {rem_ff, nq_ff[NM_W-1]};
   assign take    = trial >= {1'b0, dmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(NM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         nq_ff   <= num_abs[NM_W-1:0];
         dmag_ff <= den_abs[DM_W-1:0];
         rem_ff  <= '0;
         neg_ff  <= num[DIVN_W-1] ^ den[DIVD_W-1];
      end else if (busy_ff) begin
         nq_ff  <= {nq_ff[NM_W-2:0], take};
         rem_ff <= take ? DM_W'(trial - {1'b0, dmag_ff}) : trial[DM_W-1:0];
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed({1'b0, nq_ff}) : $signed({1'b0, nq_ff});
endmodule

[rtl/rsc_checker.sv]
// Port-level checks of the ray/sphere closest-hit block and their binding.
`timescale 1ns / 1ps
module rsc_checker
   import rsc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      req_type,
   input logic                      rsp_valid,
   input logic                      rsp_hit,
   input logic [3:0]                rsp_hit_index
);
   // Only a trace beat starts work; it holds busy until its result beat.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_TRACE) |=> busy)
      else $error("trace beat accepted without busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result beat not at the end of a trace");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_index == 4'd0)
      else $error("miss reported with nonzero index");
endmodule

bind ray_sphere_closest_hit_top rsc_checker u_rsc_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_type      (req_type),
   .rsp_valid     (rsp_valid),
   .rsp_hit       (rsp_hit),
   .rsp_hit_index (rsp_hit_index)
);

[dv/ray_sphere_closest_hit_top_tb.sv]
// Self-checking testbench for the ray/sphere closest-hit block: directed table plus random loads and traces.
`timescale 1ns / 1ps
module ray_sphere_closest_hit_top_tb;
   import rsc_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int ONE = 1 << FRAC_BITS;
   localparam int NUM_PHASES = 10;
   localparam int PHASE_ITEMS = 165;

   typedef struct {
      req_kind_type      kind;
      logic [3:0]        slot;
      logic signed [31:0] pos [3];
      logic signed [31:0] dir [3];
      logic [LEN_W-1:0]  len;
   } ray_item_type;

   typedef struct packed {
      logic             hit;
      logic [3:0]       index;
      logic [LEN_W-1:0] distance;
   } hit_result_type;

   typedef struct {
      ray_item_type   item;
      int             set_count;
      bit             fixed;
      hit_result_type fixed_result;
   } stim_row_type;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      start = 0;
   logic                      busy;
   logic                      req_type = 0;
   logic [3:0]                req_slot = 0;
   logic signed [COORD_W-1:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [COORD_W-1:0] req_dir_x = 0, req_dir_y = 0, req_dir_z = 0;
   logic [LEN_W-1:0]          req_length = 0;
   logic                      rsp_valid, rsp_hit;
   logic [3:0]                rsp_hit_index;
   logic [LEN_W-1:0]          rsp_hit_dist;
   logic                      csr_we = 0;
   logic [CNT_W-1:0]          csr_wdata = 0;

   // Predictor state.
   longint          center_x [TABLE_DEPTH];
   longint          center_y [TABLE_DEPTH];
   longint          center_z [TABLE_DEPTH];
   longint unsigned radius_sq [TABLE_DEPTH];
   bit              slot_loaded [TABLE_DEPTH];
   int unsigned     sphere_count_q = 0;

   hit_result_type pending_hits [$];
   stim_row_type   directed_rows [$];
   int             fail_count = 0;

   ray_sphere_closest_hit_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_slot(req_slot),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .req_length(req_length),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_hit_index(rsp_hit_index),
      .rsp_hit_dist(rsp_hit_dist),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      #300ms;
      $display("** ray_sphere_closest_hit_top: FAILED **");
      $finish;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Arithmetic shift is a floor division by the fixed-point scale.
   function automatic longint scale_down(longint p);
      return p >>> FRAC_BITS;
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic bit sphere_root(int k, longint ox, longint oy, longint oz,
                                      longint dx, longint dy, longint dz,
                                      output longint t);
      longint lx, ly, lz, a, h, c, disc, t0, t1, s, q, tmp;
      t = 0;
      lx = clamp32(ox - center_x[k]);
      ly = clamp32(oy - center_y[k]);
      lz = clamp32(oz - center_z[k]);
      a = clamp32(scale_down(dx * dx) + scale_down(dy * dy) + scale_down(dz * dz));
      if (a == 0) return 0;
      h = clamp32(scale_down(dx * lx) + scale_down(dy * ly) + scale_down(dz * lz));
      c = clamp32(scale_down(lx * lx) + scale_down(ly * ly) + scale_down(lz * lz)
                  - longint'(radius_sq[k]));
      disc = h * h - a * c;
      if (disc < 0) return 0;
      if (disc == 0) begin
         t0 = (-h * ONE) / a;
         t1 = t0;
      end else begin
         s = longint'(floor_root(longint'(disc)));
         q = (h > 0) ? -(h + s) : (s - h);
         t0 = (q * ONE) / a;
         t1 = (c * ONE) / q;
      end
      if (t0 > t1) begin
         tmp = t0;
         t0 = t1;
         t1 = tmp;
      end
      if (t0 < 0) begin
         t0 = t1;
         if (t0 < 0) return 0;
      end
      t = t0;
      return 1;
   endfunction

   // Applies one beat to the predictor; returns 1 when a result is due.
   function automatic bit predict_closest_hit(ray_item_type it, output hit_result_type r);
      longint best, t, len;
      int n;
      r = '0;
      len = longint'(it.len);
      if (it.kind == REQ_LOAD) begin
         center_x[it.slot] = it.pos[0];
         center_y[it.slot] = it.pos[1];
         center_z[it.slot] = it.pos[2];
         radius_sq[it.slot] = (longint'(it.len) * longint'(it.len)) >> FRAC_BITS;
         slot_loaded[it.slot] = 1;
         return 0;
      end
      best = (it.len == LEN_ONES) ? 64'sh7FFF_FFFF_FFFF_FFFF : len;
      n = (sphere_count_q < TABLE_DEPTH) ? sphere_count_q : TABLE_DEPTH;
      r.distance = it.len;
      for (int k = 0; k < n; k++) begin
         if (sphere_root(k, it.pos[0], it.pos[1], it.pos[2],
                         it.dir[0], it.dir[1], it.dir[2], t) && t < best) begin
            best = t;
            r.hit = 1;
            r.index = k[3:0];
         end
      end
      if (r.hit) r.distance = (best > longint'(LEN_ONES)) ? LEN_ONES : best[LEN_W-1:0];
      return 1;
   endfunction

   always @(posedge clock) begin
      hit_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected result beat hit=%0b index=%0d dist=%h",
                     $time, rsp_hit, rsp_hit_index, rsp_hit_dist);
            fail_count++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_hit);
               fail_count++;
            end
            if (rsp_hit_index !== want.index) begin
               $display("%0t: hit_index expected %0d actual %0d",
                        $time, want.index, rsp_hit_index);
               fail_count++;
            end
            if (rsp_hit_dist !== want.distance) begin
               $display("%0t: hit_dist expected %h actual %h",
                        $time, want.distance, rsp_hit_dist);
               fail_count++;
            end
         end
      end
   end

   task automatic write_sphere_count(int value);
      start = 0;
      wait (pending_hits.size() == 0);
      repeat (20) @(negedge clock);
      csr_we = 1;
      csr_wdata = value[CNT_W-1:0];
      @(negedge clock);
      csr_we = 0;
      sphere_count_q = value;
   endtask

   // Drives one beat; fixed rows bypass the predictor's result but still update state.
   task automatic send_item(ray_item_type it, bit fixed, hit_result_type fixed_result);
      hit_result_type r;
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start = 0;
         repeat (gap) @(negedge clock);
      end
      while (busy) begin
         start = 0;
         @(negedge clock);
      end
      req_type = it.kind;
      req_slot = it.slot;
      req_pos_x = it.pos[0];
      req_pos_y = it.pos[1];
      req_pos_z = it.pos[2];
      req_dir_x = it.dir[0];
      req_dir_y = it.dir[1];
      req_dir_z = it.dir[2];
      req_length = it.len;
      start = 1;
      if (predict_closest_hit(it, r)) pending_hits = {pending_hits, fixed ? fixed_result : r};
      @(negedge clock);
   endtask

   function automatic int near_coord(int span);
      return $urandom_range(0, 2 * span * ONE) - span * ONE;
   endfunction

   function automatic ray_item_type random_item(bit is_load, logic [3:0] slot);
      ray_item_type it;
      bit noise;
      noise = ($urandom_range(0, 99) < 15);
      it.kind = is_load ? REQ_LOAD : REQ_TRACE;
      it.slot = is_load ? slot : 4'($urandom);
      for (int i = 0; i < 3; i++) begin
         it.pos[i] = noise ? $urandom : near_coord(is_load ? 20 : 30);
         it.dir[i] = noise ? $urandom : near_coord(4);
      end
      if (noise) it.len = LEN_W'($urandom);
      else if (is_load) it.len = LEN_W'($urandom_range(ONE / 2, 10 * ONE));
      else if ($urandom_range(0, 1)) it.len = LEN_ONES;
      else it.len = LEN_W'($urandom_range(0, 60 * ONE));
      return it;
   endfunction

   task automatic add_row(req_kind_type kind, int slot, int px, int py, int pz,
                          int dx, int dy, int dz, int len,
                          int set_count, bit fixed, hit_result_type res);
      stim_row_type row;
      row.item.kind = kind;
      row.item.slot = slot[3:0];
      row.item.pos = '{px, py, pz};
      row.item.dir = '{dx, dy, dz};
      row.item.len = LEN_W'(len);
      row.set_count = set_count;
      row.fixed = fixed;
      row.fixed_result = res;
      directed_rows = {directed_rows, row};
   endtask

   initial begin
      ray_item_type it;
      int phase_count;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // With no spheres counted a trace misses and returns its limit.
      add_row(REQ_TRACE, 0, 0, 0, 0, ONE, 0, 0, 1000 * ONE, -1, 1,
              '{1'b0, 4'd0, LEN_W'(1000 * ONE)});
      add_row(REQ_LOAD, 0, 10 * ONE, 0, 0, 0, 0, 0, 2 * ONE, 4, 0, '0);
      // Slot 1 duplicates slot 0 so that ties go to the lower index.
      add_row(REQ_LOAD, 1, 10 * ONE, 0, 0, 0, 0, 0, 2 * ONE, -1, 0, '0);
      add_row(REQ_LOAD, 2, -10 * ONE, 0, 0, 0, 0, 0, 3 * ONE, -1, 0, '0);
      add_row(REQ_LOAD, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -1, -1, -1,
              LEN_ONES, -1, 0, '0);
      add_row(REQ_TRACE, 0, 0, 0, 0, ONE, 0, 0, LEN_ONES, -1, 0, '0);
      add_row(REQ_TRACE, 0, 0, 0, 0, -ONE, 0, 0, 5 * ONE, -1, 0, '0);
      add_row(REQ_TRACE, 0, 0, 0, 0, -ONE, 0, 0, 20 * ONE, -1, 0, '0);
      // A zero direction misses every sphere.
      add_row(REQ_TRACE, 0, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 77 * ONE, -1, 1,
              '{1'b0, 4'd0, LEN_W'(77 * ONE)});
      add_row(REQ_TRACE, 0, 10 * ONE, 0, 0, ONE, 0, 0, LEN_ONES, -1, 0, '0);
      add_row(REQ_TRACE, 0, 20 * ONE, 0, 0, ONE, 0, 0, LEN_ONES, -1, 0, '0);
      add_row(REQ_TRACE, 0, 0, 0, 0, 0, ONE, 0, LEN_ONES, -1, 0, '0);
      add_row(REQ_TRACE, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, -1, 0, '0);
      add_row(REQ_TRACE, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, LEN_ONES, -1, 0, '0);
      // A very short direction makes the divider quotients large.
      add_row(REQ_TRACE, 0, 0, 0, 0, 256, 0, 0, LEN_ONES, -1, 0, '0);
      add_row(REQ_TRACE, 0, 0, 0, 0, 1, 0, 0, LEN_ONES, -1, 0, '0);
      add_row(REQ_LOAD, 15, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0,
              -1, 0, '0);
      add_row(REQ_TRACE, 0, -20 * ONE, 0, 0, ONE, 0, 0, LEN_ONES, -1, 0, '0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_count >= 0) write_sphere_count(directed_rows[i].set_count);
         send_item(directed_rows[i].item, directed_rows[i].fixed,
                   directed_rows[i].fixed_result);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 0) phase_count = TABLE_DEPTH;
         else if (p == NUM_PHASES - 1) phase_count = 31;
         else if ($urandom_range(0, 9) < 6) phase_count = $urandom_range(0, 4);
         else phase_count = $urandom_range(5, 31);
         write_sphere_count(phase_count);
         // Every counted entry is loaded before it can be traced.
         for (int k = 0; k < TABLE_DEPTH && k < phase_count; k++) begin
            if (!slot_loaded[k]) send_item(random_item(1, k[3:0]), 0, '0);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it = random_item($urandom_range(0, 99) < 35, 4'($urandom));
            send_item(it, 0, '0);
         end
      end
      start = 0;
      wait (pending_hits.size() == 0);
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("** ray_sphere_closest_hit_top: PASSED **");
      end else begin
         $display("** ray_sphere_closest_hit_top: FAILED **");
      end
      $finish;
   end
endmodule
